### rtl/lzw_dictionary_hash_table_unit_assert.svh
// Assertion macros for the LZW dictionary hash table unit.
`ifndef LZW_DICTIONARY_HASH_TABLE_UNIT_ASSERT_SVH
`define LZW_DICTIONARY_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, quiet while rst_n is low
`define LZWDHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZWDHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lzwdht_pkg.sv
// Package for the LZW dictionary hash table unit: word types, codes, states.
`default_nettype none

package lzwdht_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned CODE_W          = 12;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned LG_W            = 4;
  localparam logic [LG_W-1:0] LG_RESET    = 4'd9;
  localparam logic [LG_W-1:0] LG_MIN      = 4'd9;
  localparam logic [LG_W-1:0] LG_MAX      = 4'd12;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_SEED   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_LOAD    = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] prefix_code;
    logic [CHAR_W-1:0] next_char;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              found;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] prefix;
    logic [CHAR_W-1:0] chr;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_SEED,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/lzw_dictionary_hash_table_unit.sv
// LZW string dictionary: open-addressed hash of (prefix, char) pairs.
// Input channel (in_valid/in_stall/in_word): one word is a command, mode search,
// insert or clear-and-seed. Each command gives exactly one output word on
// out_valid/out_stall/out_word: code, found, status. cfg_data (table_size_log2)
// is written whenever cfg_valid is high; cfg_ready is always high.
// One command at a time: in_stall is high from acceptance until the result is
// staged in the output register; a new command may be taken while that result
// still waits on out_stall.
// The probe walk reads one slot per cycle from a single table RAM; a search,
// or an insert that passes the load check, makes 1 up to the table size in use
// probes before its output word. Clear-and-seed clears all TABLE_DEPTH slots,
// then makes 256 seed inserts. After reset a clearing pass over all TABLE_DEPTH
// slots runs before the first command is taken. A stalled result only holds the
// output register; the sequencer waits in its final state until that register
// is free.
`default_nettype none

`include "lzw_dictionary_hash_table_unit_assert.svh"

module lzw_dictionary_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = lzwdht_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lzwdht_pkg::in_word_t        in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lzwdht_pkg::out_word_t            out_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lzwdht_pkg::LG_W-1:0] cfg_data
);

  import lzwdht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = (AW > CODE_W) ? AW : CODE_W;
  localparam int unsigned SW = (AW > CODE_W + CHAR_W + 1) ? AW : CODE_W + CHAR_W + 1;
  localparam logic [LG_W-1:0] LG_CAP = (AW < LG_MAX) ? LG_W'(AW) : LG_MAX;

  state_t               state_r, state_nxt;
  logic [LG_W-1:0]      lg_r;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        step_r, step_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [CODE_W-1:0]    p_r, p_nxt;
  logic [CHAR_W-1:0]    c_r, c_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 seeding_r, seeding_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  out_word_t            res_r, res_nxt;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic [LG_W-1:0]      lg_clamp, lg_eff;
  logic [AW-1:0]        mask;
  logic [AW:0]          size;
  logic [CODE_W-1:0]    p_sel;
  logic [CHAR_W-1:0]    c_sel;
  logic [SW-1:0]        step_w;
  logic [PW-1:0]        p_sel_w, p_cur_w, idx_w;
  logic [AW-1:0]        step_sel, start_sel, idx_adv;
  logic [20:0]          load_need, load_lim;
  logic                 load_over;
  logic                 hit, usable, last_probe;
  logic                 out_free;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  slot_t                ram_wdata, rd;

  lzwdht_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_nxt),
    .rdata(rd)
  );

  // size in use
  always_comb begin
    lg_clamp = lg_r;
    if (lg_r < LG_MIN) begin
      lg_clamp = LG_MIN;
    end else if (lg_r > LG_MAX) begin
      lg_clamp = LG_MAX;
    end
    lg_eff = (lg_clamp > LG_CAP) ? LG_CAP : lg_clamp;
  end

  assign mask = ~({AW{1'b1}} << lg_eff);
  assign size = {1'b0, mask} + {{AW{1'b0}}, 1'b1};

  // pair for a new walk: from the input word, or a seed char with empty prefix
  assign p_sel     = (state_r == ST_SEED) ? '0 : in_word.prefix_code;
  assign c_sel     = (state_r == ST_SEED) ? ch_r : in_word.next_char;
  assign step_w    = SW'({p_sel, c_sel, 1'b1});
  assign p_sel_w   = PW'(p_sel);
  assign step_sel  = step_w[AW-1:0] & mask;
  assign start_sel = p_sel_w[AW-1:0] & mask;
  assign idx_adv   = (idx_r + step_r) & mask;

  assign load_need = 21'({1'b0, count_r} + 14'd1) * 21'd100;
  assign load_lim  = 21'(21'd99 << lg_eff);
  assign load_over = load_need > load_lim;

  assign p_cur_w    = PW'(p_r);
  assign idx_w      = PW'(idx_r);
  assign hit        = rd.valid && (rd.prefix == p_r) && (rd.chr == c_r);
  assign usable     = !rd.valid && (idx_r != '0) && (idx_w != p_cur_w);
  assign last_probe = (k_r == mask);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    k_nxt       = k_r;
    clr_nxt     = clr_r;
    p_nxt       = p_r;
    c_nxt       = c_r;
    mode_nxt    = mode_r;
    seeding_nxt = seeding_r;
    ch_nxt      = ch_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = '{valid: 1'b1, prefix: p_r, chr: c_r};
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          ch_nxt    = '0;
          state_nxt = seeding_r ? ST_SEED : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt  = '{code: '0, found: 1'b0, status: STATUS_OK};
          mode_nxt = in_word.mode;
          p_nxt    = p_sel;
          c_nxt    = c_sel;
          idx_nxt  = start_sel;
          step_nxt = step_sel;
          k_nxt    = '0;
          case (in_word.mode)
            MODE_SEARCH: state_nxt = ST_PROBE;
            MODE_INSERT: state_nxt = ST_CHECK;
            MODE_SEED: begin
              seeding_nxt = 1'b1;
              count_nxt   = '0;
              clr_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CHECK: begin
        if (load_over) begin
          res_nxt.status = STATUS_LOAD;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_SEED: begin
        mode_nxt  = MODE_INSERT;
        p_nxt     = p_sel;
        c_nxt     = c_sel;
        idx_nxt   = start_sel;
        step_nxt  = step_sel;
        k_nxt     = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if ((mode_r == MODE_SEARCH) ? hit : usable) begin
          res_nxt.code  = idx_w[CODE_W-1:0];
          res_nxt.found = 1'b1;
          if (mode_r != MODE_SEARCH) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else if (last_probe) begin
          if (mode_r != MODE_SEARCH) begin
            res_nxt.status = STATUS_NO_SLOT;
          end
        end else begin
          idx_nxt = idx_adv;
          k_nxt   = k_r + 1'b1;
        end
        if (((mode_r == MODE_SEARCH) ? hit : usable) || last_probe) begin
          if (seeding_r) begin
            res_nxt = '{code: '0, found: 1'b0, status: STATUS_OK};
            if (ch_r == {CHAR_W{1'b1}}) begin
              seeding_nxt = 1'b0;
              state_nxt   = ST_DONE;
            end else begin
              ch_nxt    = ch_r + 1'b1;
              state_nxt = ST_SEED;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      seeding_r <= 1'b0;
      count_r   <= '0;
      lg_r      <= LG_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      seeding_r <= seeding_nxt;
      count_r   <= count_nxt;
      if (cfg_valid) begin
        lg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    k_r    <= k_nxt;
    p_r    <= p_nxt;
    c_r    <= c_nxt;
    mode_r <= mode_nxt;
    ch_r   <= ch_nxt;
    res_r  <= res_nxt;
  end

  // output register: a finished word waits here while a new command runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_word_r <= res_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  `LZWDHT_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "output word without a finished command")
  `LZWDHT_ASSERT_NOW(a_insert_free_slot, ram_we && state_r == ST_PROBE, !rd.valid && idx_r != '0, "insert overwrote a used slot or slot zero")
  `LZWDHT_ASSERT_NOW(a_count_bound, state_r == ST_IDLE, {1'b0, count_r} <= 14'(size), "stored count above table size")
  `LZWDHT_ASSERT_NEXT(a_seed_after_clear, state_r == ST_CLEAR && seeding_r && clr_r == {AW{1'b1}}, state_r == ST_SEED && ch_r == '0 && count_r == '0, "seeding did not follow the clearing pass")

endmodule

`default_nettype wire

### rtl/lzwdht_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lzwdht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for the LZW dictionary hash table unit: directed table, LZW-style random streams.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwdht_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned SLOTS = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    in_word_t  cmd;
    bit        typed;
    out_word_t res;
  } cmd_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LG_W-1:0]     cfg_data = '0;

  // dictionary model state
  bit                  tab_used [SLOTS];
  logic [CODE_W-1:0]   tab_prefix [SLOTS];
  logic [CHAR_W-1:0]   tab_char [SLOTS];
  logic [COUNT_W-1:0]  tab_count;
  logic [LG_W-1:0]     tab_lg;

  out_word_t           res_q [$];
  out_word_t           exp_w;
  cmd_row_t            dir_q [$];
  int                  err_cnt = 0;
  int                  got_cnt = 0;
  int                  cyc_cnt = 0;
  int                  tx_idle_pct = 25;
  int                  rx_stall_pct = 20;
  bit                  held = 1'b0;

  lzw_dictionary_hash_table_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned dict_size();
    int unsigned lg;
    lg = tab_lg;
    if (lg < LG_MIN) lg = LG_MIN;
    if (lg > LG_MAX) lg = LG_MAX;
    if ((1 << lg) > SLOTS) return SLOTS;
    return 1 << lg;
  endfunction

  function automatic logic [CODE_W-1:0] dict_find(input logic [CODE_W-1:0] p,
                                                  input logic [CHAR_W-1:0] c,
                                                  output bit hit);
    int unsigned sz, mask, stp, idx, pc;
    sz = dict_size();
    mask = sz - 1;
    pc = {p, c};
    stp = (2 * pc + 1) & mask;
    idx = p & mask;
    for (int unsigned k = 0; k < sz; k++) begin
      if (tab_used[idx] && tab_prefix[idx] == p && tab_char[idx] == c) begin
        hit = 1'b1;
        return idx[CODE_W-1:0];
      end
      idx = (idx + stp) & mask;
    end
    hit = 1'b0;
    return '0;
  endfunction

  function automatic logic [1:0] dict_store(input logic [CODE_W-1:0] p,
                                            input logic [CHAR_W-1:0] c,
                                            output logic [CODE_W-1:0] slot);
    int unsigned sz, mask, stp, idx, pc, cnt;
    sz = dict_size();
    mask = sz - 1;
    pc = {p, c};
    stp = (2 * pc + 1) & mask;
    idx = p & mask;
    cnt = tab_count;
    slot = '0;
    if (100 * (cnt + 1) > 99 * sz) return STATUS_LOAD;
    for (int unsigned k = 0; k < sz; k++) begin
      // slot 0 and the slot numbered like the prefix are never handed out
      if (!tab_used[idx] && idx != 0 && idx != p) begin
        tab_used[idx] = 1'b1;
        tab_prefix[idx] = p;
        tab_char[idx] = c;
        tab_count = tab_count + 1'b1;
        slot = idx[CODE_W-1:0];
        return STATUS_OK;
      end
      idx = (idx + stp) & mask;
    end
    return STATUS_NO_SLOT;
  endfunction

  function automatic out_word_t dict_apply(input in_word_t w);
    out_word_t r;
    bit hit;
    logic [CODE_W-1:0] slot;
    r = '0;
    case (w.mode)
      MODE_SEARCH: begin
        r.code = dict_find(w.prefix_code, w.next_char, hit);
        r.found = hit;
      end
      MODE_INSERT: begin
        r.status = dict_store(w.prefix_code, w.next_char, slot);
        r.code = slot;
        r.found = (r.status == STATUS_OK);
      end
      MODE_SEED: begin
        for (int i = 0; i < SLOTS; i++) tab_used[i] = 1'b0;
        tab_count = '0;
        for (int ch = 0; ch < 256; ch++) void'(dict_store('0, ch[CHAR_W-1:0], slot));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_row_t row(input logic [1:0] m, input logic [CODE_W-1:0] p,
                                   input logic [CHAR_W-1:0] c, input bit typed,
                                   input logic [CODE_W-1:0] code, input logic f,
                                   input logic [1:0] st);
    cmd_row_t t;
    t.cmd = '{m, p, c};
    t.typed = typed;
    t.res = '{code, f, st};
    return t;
  endfunction

  // enters and leaves on a falling edge
  task automatic issue(input in_word_t w, input bit typed, input out_word_t typed_res,
                       output out_word_t r);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = dict_apply(w);
    if (typed) res_q.push_back(typed_res);
    else res_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [LG_W-1:0] v, input int tx_pct, input int rx_pct);
    in_valid <= 1'b0;
    while (res_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tab_lg = v;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // LZW encoder streams over a small alphabet, mixed with noise words
  task automatic run_phase(input logic [LG_W-1:0] lg, input bit reseed, input int n_items,
                           input int alpha, input int tx_pct, input int rx_pct,
                           input int noise_pct, input int ins_pct, input bit seed_ok);
    int sent;
    int pick;
    bit hit;
    logic [CODE_W-1:0] cur;
    logic [CHAR_W-1:0] c, base;
    in_word_t w;
    out_word_t r;
    cfg_write(lg, tx_pct, rx_pct);
    sent = 0;
    if (reseed) begin
      issue('{MODE_SEED, 12'($urandom), 8'($urandom)}, 1'b0, '0, r);
      sent++;
    end
    base = 8'($urandom);
    cur = dict_find('0, base, hit);
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        w.prefix_code = 12'($urandom);
        w.next_char = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) w.mode = MODE_INSERT;
        else if (pick < 96) w.mode = ($urandom_range(0, 2) == 0) ? MODE_UNUSED : MODE_SEARCH;
        else w.mode = seed_ok ? MODE_SEED : MODE_UNUSED;
        issue(w, 1'b0, '0, r);
        sent++;
      end else begin
        c = base + 8'($urandom_range(0, alpha - 1));
        issue('{MODE_SEARCH, cur, c}, 1'b0, '0, r);
        sent++;
        if (r.found) begin
          cur = r.code;
        end else begin
          issue('{MODE_INSERT, cur, c}, 1'b0, '0, r);
          sent++;
          cur = dict_find('0, c, hit);
        end
      end
    end
  endtask

  // result side: random stall bursts plus one long hold-off to back the block up
  initial begin
    forever begin
      @(negedge clk);
      if (!held && got_cnt >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_cnt++;
      if (res_q.size() == 0) begin
        $display("%0t: result word with nothing expected: code %0d found %0b status %0d",
                 $realtime, out_word.code, out_word.found, out_word.status);
        err_cnt++;
      end else begin
        exp_w = res_q.pop_front();
        if (out_word.code !== exp_w.code) begin
          $display("%0t: code mismatch: expected %0d, actual %0d",
                   $realtime, exp_w.code, out_word.code);
          err_cnt++;
        end
        if (out_word.found !== exp_w.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $realtime, exp_w.found, out_word.found);
          err_cnt++;
        end
        if (out_word.status !== exp_w.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, exp_w.status, out_word.status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $realtime);
      $display("** lzw_dictionary_hash_table_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    out_word_t r;
    for (int i = 0; i < SLOTS; i++) tab_used[i] = 1'b0;
    tab_count = '0;
    tab_lg = LG_RESET;

    // table starts empty and unseeded
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'h00, 1'b1, 12'd0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'hFFF, 8'hFF, 1'b1, 12'd0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_UNUSED, 12'hFFF, 8'hFF, 1'b1, 12'd0, 1'b0, STATUS_OK));
    // home slot 0 is barred, step is 1
    dir_q.push_back(row(MODE_INSERT, 12'h000, 8'h00, 1'b1, 12'd1, 1'b1, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'h00, 1'b0, '0, 1'b0, STATUS_OK));
    // duplicate pair goes to a second slot; search still returns the first
    dir_q.push_back(row(MODE_INSERT, 12'h000, 8'h00, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'h00, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_INSERT, 12'hFFF, 8'hFF, 1'b0, '0, 1'b0, STATUS_OK));
    // home slot equals the prefix code
    dir_q.push_back(row(MODE_INSERT, 12'h005, 8'h80, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h005, 8'h80, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEED, 12'hFFF, 8'hFF, 1'b1, 12'd0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'h41, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'hFF, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h000, 8'h00, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_INSERT, 12'h123, 8'h45, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'h123, 8'h45, 1'b0, '0, 1'b0, STATUS_OK));
    // prefix beyond the table size in use
    dir_q.push_back(row(MODE_INSERT, 12'hABC, 8'h5A, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'hABC, 8'h5A, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_UNUSED, 12'h000, 8'h00, 1'b1, 12'd0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEARCH, 12'hFFF, 8'h00, 1'b1, 12'd0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_INSERT, 12'h800, 8'hFF, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_INSERT, 12'h7FF, 8'h01, 1'b0, '0, 1'b0, STATUS_OK));
    dir_q.push_back(row(MODE_SEED, 12'h000, 8'h00, 1'b1, 12'd0, 1'b0, STATUS_OK));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_q[i]) issue(dir_q[i].cmd, dir_q[i].typed, dir_q[i].res, r);

    run_phase(4'd10, 1'b1, 150, 6, 25, 20, 20, 40, 1'b1);
    // small table driven into the load limit
    run_phase(4'd9, 1'b1, 480, 12, 15, 15, 60, 80, 1'b0);
    // size change with no reseed
    run_phase(4'd12, 1'b0, 30, 8, 30, 30, 30, 40, 1'b0);
    run_phase(4'd15, 1'b1, 40, 8, 0, 0, 20, 40, 1'b0);
    run_phase(4'd0, 1'b1, 120, 5, 40, 40, 20, 40, 1'b1);
    run_phase(4'd11, 1'b1, 80, 8, 25, 25, 20, 40, 1'b0);
    run_phase(4'd8, 1'b0, 60, 8, 25, 25, 30, 50, 1'b0);
    run_phase(4'd9, 1'b1, 80, 6, 0, 0, 20, 40, 1'b0);

    in_valid <= 1'b0;
    while (res_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 64) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** lzw_dictionary_hash_table_unit: PASSED **");
    end else begin
      $display("** lzw_dictionary_hash_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/lzwdht_pkg.sv
rtl/lzwdht_ram.sv
rtl/lzw_dictionary_hash_table_unit.sv
verif/testbench.sv
